FILE: rtl/core/mep_pkg.sv
// ----------------------------------------------------------------------------
// mep_pkg
// Shared constants, types and helpers of the Mandelbrot escape pixel unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mep_pkg;

  localparam int IMAGE_SIZE = 1024;
  localparam int HALF_SIZE  = IMAGE_SIZE / 2;

  localparam int WORD_W     = 64;
  localparam int WIDE_W     = 2 * WORD_W;
  localparam int FRAC_BITS  = 52;
  localparam int ZOOM_LIMIT = 48;

  localparam int CENTER_W   = 57;
  localparam int ZOOM_W     = 6;
  localparam int ITER_W     = 10;
  localparam int PIX_W      = 10;
  localparam int CFG_DATA_W = 57;
  localparam int CFG_IDX_W  = 2;

  // Multiplier operand split: magnitudes are at most 2^53.
  localparam int MAG_W  = 54;
  localparam int LO_W   = 26;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int PROD_W = 2 * MAG_W;
  localparam int RES_W  = PROD_W - FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 2'd3;

  localparam logic [ITER_W-1:0] MAX_ITER_RESET = 10'd256;

  typedef logic signed [WORD_W-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam word_t TWO      = word_t'(64'd1 << (FRAC_BITS + 1));
  localparam word_t NEG_TWO  = -TWO;
  localparam word_t FOUR     = word_t'(64'd1 << (FRAC_BITS + 2));

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ITER_W-1:0] count;
  } seq_status_t;

  // Clamp a 65-bit sum to the signed 64-bit range.
  function automatic word_t sat_word(input logic signed [WORD_W:0] s);
    word_t r;
    if (s[WORD_W] != s[WORD_W-1]) begin
      r = s[WORD_W] ? WORD_MIN : WORD_MAX;
    end else begin
      r = s[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/mep_qmul.sv
// ----------------------------------------------------------------------------
// mep_qmul
// Pipelined signed Q52 multiplier, registered magnitudes, partial products and
// result; one request per cycle. Magnitude truncated toward zero, then signed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mep_qmul (
  input  logic          clk,
  input  mep_pkg::word_t a,
  input  mep_pkg::word_t b,
  output mep_pkg::word_t p
);
  import mep_pkg::*;

  word_t                  abs_a;
  word_t                  abs_b;
  logic [MAG_W-1:0]       ma;
  logic [MAG_W-1:0]       mb;
  logic                   neg0;
  logic [2*HI_W-1:0]      hh;
  logic [HI_W+LO_W-1:0]   hl;
  logic [HI_W+LO_W-1:0]   lh;
  logic [2*LO_W-1:0]      ll;
  logic                   neg1;
  logic [PROD_W-1:0]      full;
  logic [RES_W-1:0]       mag_r;
  word_t                  p_next;

  assign abs_a = a[WORD_W-1] ? -a : a;
  assign abs_b = b[WORD_W-1] ? -b : b;

  always_ff @(posedge clk) begin
    ma   <= abs_a[MAG_W-1:0];
    mb   <= abs_b[MAG_W-1:0];
    neg0 <= a[WORD_W-1] ^ b[WORD_W-1];
  end

  always_ff @(posedge clk) begin
    hh   <= ma[MAG_W-1:LO_W] * mb[MAG_W-1:LO_W];
    hl   <= ma[MAG_W-1:LO_W] * mb[LO_W-1:0];
    lh   <= ma[LO_W-1:0] * mb[MAG_W-1:LO_W];
    ll   <= ma[LO_W-1:0] * mb[LO_W-1:0];
    neg1 <= neg0;
  end

  always_comb begin
    full   = (PROD_W'(hh) << (2 * LO_W))
           + ((PROD_W'(hl) + PROD_W'(lh)) << LO_W)
           + PROD_W'(ll);
    mag_r  = full[PROD_W-1:FRAC_BITS];
    p_next = neg1 ? -word_t'(mag_r) : word_t'(mag_r);
  end

  always_ff @(posedge clk) begin
    p <= p_next;
  end

endmodule

FILE: rtl/core/mep_seq.sv
// ----------------------------------------------------------------------------
// mep_seq
// Per-pixel sequencer: maps the pixel to c on a shared shift/add path, then
// runs z = z*z + c with three requests per iteration to the shared multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mep_seq (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [mep_pkg::PIX_W-1:0]            pixel_row,
  input  logic [mep_pkg::PIX_W-1:0]            pixel_col,
  input  logic signed [mep_pkg::CENTER_W-1:0]  center_x,
  input  logic signed [mep_pkg::CENTER_W-1:0]  center_y,
  input  logic [mep_pkg::ZOOM_W-1:0]           zoom,
  input  logic [mep_pkg::ITER_W-1:0]           max_iterations,
  input  logic                                 take,
  output mep_pkg::seq_status_t                 status
);
  import mep_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MAP_R  = 4'd1;
  localparam logic [3:0] ST_MAP_I  = 4'd2;
  localparam logic [3:0] ST_CHECK  = 4'd3;
  localparam logic [3:0] ST_ISS_II = 4'd4;
  localparam logic [3:0] ST_ISS_RI = 4'd5;
  localparam logic [3:0] ST_GET_RR = 4'd6;
  localparam logic [3:0] ST_GET_II = 4'd7;
  localparam logic [3:0] ST_UPDATE = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  logic [3:0]              state;
  logic [3:0]              state_next;
  logic [PIX_W-1:0]        row;
  logic [PIX_W-1:0]        col;
  logic [ZOOM_W-1:0]       shift;
  logic [ITER_W-1:0]       limit;
  logic [ITER_W-1:0]       count;
  word_t                   cr;
  word_t                   ci;
  word_t                   zr;
  word_t                   zi;
  word_t                   r2;
  word_t                   diff;

  logic [ZOOM_W-1:0]       zoom_clamp;
  logic [ZOOM_W-1:0]       shift_next;

  logic signed [CENTER_W-1:0] map_center;
  logic [PIX_W-1:0]        map_pix;
  word_t                   d;
  word_t                   abs_d;
  logic [WIDE_W-1:0]       m;
  word_t                   off;
  logic signed [WORD_W:0]  c_ext;
  logic signed [WORD_W:0]  map_sum;
  word_t                   map_c;

  word_t                   mul_a;
  word_t                   mul_b;
  word_t                   mul_p;
  word_t                   sum_sq;
  word_t                   ri2;
  logic                    escaped;

  mep_qmul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign mul_a = (state == ST_ISS_II) ? zi : zr;
  assign mul_b = (state == ST_CHECK) ? zr : zi;

  assign zoom_clamp = (zoom > ZOOM_W'(ZOOM_LIMIT)) ? ZOOM_W'(ZOOM_LIMIT) : zoom;
  assign shift_next = ZOOM_W'(FRAC_BITS) - zoom_clamp;

  // Shared axis mapper: c = center - (HALF_SIZE - pixel) * 2^-zoom, saturating.
  always_comb begin
    map_center = (state == ST_MAP_R) ? center_x : center_y;
    map_pix    = (state == ST_MAP_R) ? row : col;
    d          = word_t'(HALF_SIZE) - word_t'({{(WORD_W-PIX_W){1'b0}}, map_pix});
    abs_d      = d[WORD_W-1] ? -d : d;
    m          = {{WORD_W{1'b0}}, abs_d} << shift;
    off        = (|m[WIDE_W-1:WORD_W-1]) ? WORD_MAX : m[WORD_W-1:0];
    c_ext      = {{(WORD_W+1-CENTER_W){map_center[CENTER_W-1]}}, map_center};
    if (!d[WORD_W-1] && (d != '0)) begin
      map_sum = c_ext - {1'b0, off};
    end else begin
      map_sum = c_ext + {1'b0, off};
    end
    map_c = sat_word(map_sum);
  end

  assign escaped = (zr > TWO) || (zr < NEG_TWO) || (zi > TWO) || (zi < NEG_TWO);
  assign sum_sq  = r2 + mul_p;
  assign ri2     = mul_p <<< 1;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_MAP_R;
      ST_MAP_R:  state_next = ST_MAP_I;
      ST_MAP_I:  state_next = ST_CHECK;
      ST_CHECK:  begin
        if ((count >= limit) || escaped) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_ISS_II;
        end
      end
      ST_ISS_II: state_next = ST_ISS_RI;
      ST_ISS_RI: state_next = ST_GET_RR;
      ST_GET_RR: state_next = ST_GET_II;
      ST_GET_II: state_next = (sum_sq > FOUR) ? ST_DONE : ST_UPDATE;
      ST_UPDATE: state_next = ST_CHECK;
      ST_DONE:   if (take) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      limit <= '0;
    end else begin
      state <= state_next;
      if (start && (state == ST_IDLE)) begin
        count <= '0;
        limit <= max_iterations;
      end else if (state == ST_UPDATE) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && (state == ST_IDLE)) begin
      row   <= pixel_row;
      col   <= pixel_col;
      shift <= shift_next;
    end
    if (state == ST_MAP_R) begin
      cr <= map_c;
    end
    if (state == ST_MAP_I) begin
      ci <= map_c;
      zr <= '0;
      zi <= '0;
    end
    if (state == ST_GET_RR) begin
      r2 <= mul_p;
    end
    if (state == ST_GET_II) begin
      diff <= r2 - mul_p;
    end
    if (state == ST_UPDATE) begin
      zr <= sat_word({diff[WORD_W-1], diff} + {cr[WORD_W-1], cr});
      zi <= sat_word({ri2[WORD_W-1], ri2} + {ci[WORD_W-1], ci});
    end
  end

  assign status.busy  = (state != ST_IDLE);
  assign status.done  = (state == ST_DONE);
  assign status.count = count;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (count <= limit))
    else $error("iteration count passed the cutoff");

  a_mul_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ISS_II) |->
      (zr <= TWO && zr >= NEG_TWO && zi <= TWO && zi >= NEG_TWO))
    else $error("multiplier operand outside two");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == ST_IDLE))
    else $error("request started while busy");

  a_take_done: assert property (@(posedge clk) disable iff (rst)
    take |-> (state == ST_DONE))
    else $error("result taken before done");
`endif

endmodule

FILE: rtl/core/mandelbrot_escape_pixel_unit.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_unit
// Escape-time count of one Mandelbrot pixel. A request carries a pixel row
// and column; the unit maps it to c around the configured center with a step
// of 2^-zoom (Q52 fixed point), iterates z = z*z + c from zero and returns
// the first count at which |z|^2 > 4, or max_iterations. One pixel is in
// work at a time: the unit maps the real and then the imaginary part, then
// runs each iteration as three products through the shared three-stage
// multiplier between checks of the count and of escape, and after the final
// test hands the result to the output register. A new request is taken
// while a finished result waits on the output. Write configuration only
// while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandelbrot_escape_pixel_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [mep_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mep_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mep_pkg::PIX_W-1:0]         pixel_row,
  input  logic [mep_pkg::PIX_W-1:0]         pixel_col,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mep_pkg::ITER_W-1:0]        escape_count
);
  import mep_pkg::*;

  logic signed [CENTER_W-1:0] center_x;
  logic signed [CENTER_W-1:0] center_y;
  logic [ZOOM_W-1:0]          zoom;
  logic [ITER_W-1:0]          max_iterations;
  seq_status_t                status;
  logic                       start;
  logic                       take;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= '0;
      center_y       <= '0;
      zoom           <= '0;
      max_iterations <= MAX_ITER_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CENTER_X: center_x       <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y: center_y       <= cfg_data[CENTER_W-1:0];
        REG_ZOOM:     zoom           <= cfg_data[ZOOM_W-1:0];
        REG_MAX_ITER: max_iterations <= cfg_data[ITER_W-1:0];
        default:      ;
      endcase
    end
  end

  assign in_stall = status.busy;
  assign start    = in_valid && !in_stall;
  assign take     = status.done && (!out_valid || !out_stall);

  mep_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .pixel_row      (pixel_row),
    .pixel_col      (pixel_col),
    .center_x       (center_x),
    .center_y       (center_y),
    .zoom           (zoom),
    .max_iterations (max_iterations),
    .take           (take),
    .status         (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      escape_count <= status.count;
    end
  end

endmodule
